// File: hdl/bls_pkg.sv
// Shared types, sizes and word-format helpers for the bounded LIFO stack.
// Used by bls_cell and bounded_lifo_stack_unit; depends on nothing else.
package bls_pkg;

   // Built size of the stack and stored word width
   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;

   // Fixed field widths of the ports
   localparam int WORD_W    = 32;
   localparam int CAP_W     = 7;
   localparam int POS_W     = 7;
   localparam int CNT_OUT_W = 7;

   // Internal count width and the width used for count/capacity compares
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_PEEK = 2'd2,
      CMD_TOP  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_BADPOS    = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      FSM_IDLE = 1'b0,
      FSM_PEEK = 1'b1
   } fsm_type;

   // Per-cycle control broadcast to every cell of the chain
   typedef struct packed {
      logic push;   // entries move one cell down, new word enters at the top
      logic pop;    // entries move one cell up
      logic load;   // copy each entry into its read lane
      logic shift;  // read lane moves one cell up
   } cell_ctrl_type;

   // Cut or sign-extend a 32-bit push word to the stored width
   function automatic logic [DATA_WIDTH-1:0] to_entry(input logic [WORD_W-1:0] v);
      logic [WORD_W+63:0] ext;
      ext = {{64{v[WORD_W-1]}}, v};
      return ext[DATA_WIDTH-1:0];
   endfunction

   // Sign-extend a stored word, then cut it to the 32-bit data field
   function automatic logic [WORD_W-1:0] to_word(input logic [DATA_WIDTH-1:0] w);
      logic [DATA_WIDTH+WORD_W-1:0] ext;
      ext = {{WORD_W{w[DATA_WIDTH-1]}}, w};
      return ext[WORD_W-1:0];
   endfunction

endpackage

// File: hdl/bls_cell.sv
// One stack cell: an entry register plus a read-lane register.
// Depends on bls_pkg for the word width and the cell control struct.
module bls_cell (
   input  logic                               clock,
   input  bls_pkg::cell_ctrl_type             ctrl,
   input  logic [bls_pkg::DATA_WIDTH-1:0]     above_entry,
   input  logic [bls_pkg::DATA_WIDTH-1:0]     below_entry,
   input  logic [bls_pkg::DATA_WIDTH-1:0]     below_lane,
   output logic [bls_pkg::DATA_WIDTH-1:0]     entry_out,
   output logic [bls_pkg::DATA_WIDTH-1:0]     lane_out
);

   logic [bls_pkg::DATA_WIDTH-1:0] entry_ff;
   logic [bls_pkg::DATA_WIDTH-1:0] entry_in;
   logic [bls_pkg::DATA_WIDTH-1:0] lane_ff;
   logic [bls_pkg::DATA_WIDTH-1:0] lane_in;

   // Take the neighbor's entry on push or pop, else hold
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         entry_in = above_entry;
      end else if (ctrl.pop) begin
         entry_in = below_entry;
      end
   end

   // Snapshot the entry, or advance the lane toward the top
   always_comb begin
      lane_in = lane_ff;
      if (ctrl.load) begin
         lane_in = entry_ff;
      end else if (ctrl.shift) begin
         lane_in = below_lane;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lane_ff  <= lane_in;
   end

   assign entry_out = entry_ff;
   assign lane_out  = lane_ff;

endmodule

// File: hdl/bounded_lifo_stack_unit.sv
// Top level of the bounded LIFO stack: command control, count, capacity and result register.
// Depends on bls_pkg and bls_cell (a row of DEPTH cells, cell 0 holds the top).
//
// Stack of signed words kept in a chain of cells; cell 0 always holds the top word.
// Push, pop and read top each load the result register on acceptance, and a new command
// can be accepted every cycle while the result register drains. Peek at position p first
// copies the entries into a read lane, then makes p-1 moves of that lane one cell toward
// the top to bring entry p to cell 0, and last loads the result register once it is free.
// The capacity register may only be written while idle; 0 acts as 1 and values above the
// built depth act as the depth. No clearing pass after reset.
module bounded_lifo_stack_unit (
   input  logic                            clock,
   input  logic                            reset,
   // command channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_command,
   input  logic signed [bls_pkg::WORD_W-1:0] req_push_value,
   input  logic [bls_pkg::POS_W-1:0]       req_position,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [bls_pkg::WORD_W-1:0] rsp_data,
   output logic [1:0]                      rsp_status,
   output logic [bls_pkg::CNT_OUT_W-1:0]   rsp_count,
   output logic                            rsp_is_full,
   output logic                            rsp_is_empty,
   // capacity register
   input  logic                            csr_wr_en,
   input  logic [bls_pkg::CAP_W-1:0]       csr_wr_data
);

   localparam int DEPTH = bls_pkg::DEPTH;
   localparam int DW    = bls_pkg::DATA_WIDTH;
   localparam int CNT_W = bls_pkg::CNT_W;
   localparam int CMP_W = bls_pkg::CMP_W;

   bls_pkg::fsm_type          state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          shift_cnt_ff, shift_cnt_in;
   logic [bls_pkg::CAP_W-1:0] capacity_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [bls_pkg::WORD_W-1:0] rsp_data_ff, rsp_data_in;
   bls_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic [bls_pkg::CNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                      rsp_full_ff, rsp_full_in;
   logic                      rsp_empty_ff, rsp_empty_in;

   bls_pkg::cell_ctrl_type    ctrl;
   logic                      accept;
   logic                      out_free;
   logic                      load_rsp;
   logic [CMP_W-1:0]          cap_eff;
   logic [CMP_W-1:0]          count_wide;
   logic [CMP_W-1:0]          pos_wide;
   logic [DW-1:0]             push_entry;

   logic [DW-1:0] entry [DEPTH];
   logic [DW-1:0] lane  [DEPTH];

   // Row of cells: push moves words down, pop moves them up, lane moves up
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DW-1:0] above_w;
      logic [DW-1:0] below_w;
      logic [DW-1:0] below_l;

      if (i == 0) begin : g_top
         assign above_w = push_entry;
      end else begin : g_mid
         assign above_w = entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_bottom
         assign below_w = '0;
         assign below_l = '0;
      end else begin : g_inner
         assign below_w = entry[i+1];
         assign below_l = lane[i+1];
      end

      bls_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .above_entry (above_w),
         .below_entry (below_w),
         .below_lane  (below_l),
         .entry_out   (entry[i]),
         .lane_out    (lane[i])
      );
   end

   assign push_entry = bls_pkg::to_entry(req_push_value);

   // Clamp capacity to 1..DEPTH
   always_comb begin
      cap_eff = CMP_W'(capacity_ff);
      if (cap_eff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_eff > CMP_W'(DEPTH)) begin
         cap_eff = CMP_W'(DEPTH);
      end
   end

   assign count_wide = CMP_W'(count_ff);
   assign pos_wide   = CMP_W'(req_position);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == bls_pkg::FSM_IDLE) && out_free;
   assign accept     = req_valid && req_ready;

   // Decode the command, drive the cells and build the result
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      shift_cnt_in  = shift_cnt_ff;
      ctrl          = '0;
      load_rsp      = 1'b0;
      rsp_data_in   = '0;
      rsp_status_in = bls_pkg::ST_OK;

      case (state_ff)
         bls_pkg::FSM_IDLE: begin
            if (accept) begin
               case (req_command)
                  bls_pkg::CMD_PUSH: begin
                     load_rsp = 1'b1;
                     if (count_wide >= cap_eff) begin
                        rsp_status_in = bls_pkg::ST_OVERFLOW;
                     end else begin
                        ctrl.push = 1'b1;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  bls_pkg::CMD_POP: begin
                     load_rsp = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = bls_pkg::ST_UNDERFLOW;
                     end else begin
                        ctrl.pop    = 1'b1;
                        count_in    = count_ff - 1'b1;
                        rsp_data_in = bls_pkg::to_word(entry[0]);
                     end
                  end
                  bls_pkg::CMD_PEEK: begin
                     if (pos_wide == '0 || pos_wide > count_wide) begin
                        load_rsp      = 1'b1;
                        rsp_status_in = bls_pkg::ST_BADPOS;
                     end else begin
                        ctrl.load    = 1'b1;
                        shift_cnt_in = pos_wide[CNT_W-1:0] - 1'b1;
                        state_in     = bls_pkg::FSM_PEEK;
                     end
                  end
                  default: begin
                     // read top
                     load_rsp = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = bls_pkg::ST_UNDERFLOW;
                     end else begin
                        rsp_data_in = bls_pkg::to_word(entry[0]);
                     end
                  end
               endcase
            end
         end
         bls_pkg::FSM_PEEK: begin
            if (shift_cnt_ff != '0) begin
               ctrl.shift   = 1'b1;
               shift_cnt_in = shift_cnt_ff - 1'b1;
            end else if (out_free) begin
               load_rsp    = 1'b1;
               rsp_data_in = bls_pkg::to_word(lane[0]);
               state_in    = bls_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = bls_pkg::FSM_IDLE;
         end
      endcase

      // Result register: load a new word, drop a taken one, else hold
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = bls_pkg::CNT_OUT_W'(count_in);
      rsp_full_in  = CMP_W'(count_in) >= cap_eff;
      rsp_empty_in = count_in == '0;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bls_pkg::FSM_IDLE;
         count_ff     <= '0;
         shift_cnt_ff <= '0;
         capacity_ff  <= bls_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         shift_cnt_ff <= shift_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_full_ff   <= rsp_full_in;
         rsp_empty_ff  <= rsp_empty_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_full  = rsp_full_ff;
   assign rsp_is_empty = rsp_empty_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_wide <= CMP_W'(DEPTH))
      else $error("stack count above built depth");

   a_peek_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == bls_pkg::FSM_PEEK |-> !req_ready)
      else $error("command accepted during peek walk");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == bls_pkg::CMD_POP && count_ff != '0)
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop did not lower the count by one");

   a_overflow_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == bls_pkg::CMD_PUSH && count_wide >= cap_eff)
      |=> $stable(count_ff))
      else $error("overflowing push changed the count");
`endif

endmodule
